/* rtl/core/bitmap_slot_allocator_defines.svh */
// Assertion helpers for the slot allocator
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
// check that an implication holds on every clock edge outside reset
`define BSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that an implication holds, reset included
`define BSA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/core/bsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Types and constants shared by the slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;
  localparam int unsigned MaxSlotsDef = 1024;
  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned CountW = 11;
  localparam int unsigned SlotW = 10;

  typedef enum logic [2:0] {
    KIND_INIT = 3'd0, KIND_TEST = 3'd1, KIND_ALLOC = 3'd2,
    KIND_ALLOC_RUN = 3'd3, KIND_FREE = 3'd4, KIND_FREE_RUN = 3'd5,
    KIND_BAD6 = 3'd6, KIND_BAD7 = 3'd7
  } kind_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SlotW-1:0]  slot_index;
    logic [CountW-1:0] run_length;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [SlotW-1:0]  granted_slot;
    logic              bit_value;
    logic [CountW-1:0] free_total;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_RD, ST_WT, ST_MOD, ST_SCAN_RD, ST_SCAN_WT,
    ST_SCAN, ST_DONE
  } state_e;
endpackage

/* rtl/core/bsa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/bitmap_slot_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Free-map slot allocator: init, test, allocate, run allocate, free, free run.
// ----------------------------------------------------------------------------
// Requests arrive on req_* (valid/stall), one result per request leaves on
// rsp_* (valid/stall). slots_in_use is written through cfg_we_i/cfg_data_i;
// the user must write it only while idle, the block itself does not enforce
// this. The free map lives in a RAM of one word per WORD_BITS slots; scans
// walk it one bit per step with read, modify, write back. A rejected request
// goes straight to the result; test and free work on a single word; allocate
// tries the hint word first, if any, then scans bits; run operations walk the
// map or run slot by slot, and a run allocate walks the granted run a second
// time to clear it. Init sweeps every word, one per cycle. The serial bit walk
// of the map sets the rate; the next request is taken the cycle after the
// result transfer. Reset marks the map all free through a sweep of one word
// per cycle before the first request is taken. While the receiver stalls, the
// result is held and no request is taken.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
  parameter int unsigned WORD_BITS = bsa_pkg::WordBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [10:0]   cfg_data_i,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  bsa_pkg::req_t req_data_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output bsa_pkg::rsp_t rsp_data_o
);
  import bsa_pkg::*;
  `include "bitmap_slot_allocator_defines.svh"

  localparam int unsigned MAX_SLOTS = MaxSlotsDef;
  localparam int unsigned NWords = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);
  localparam int unsigned SW = $clog2(MAX_SLOTS) + 2;

  state_e st_q, st_d;
  logic [10:0] cfg_q;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] hint_q, hint_d;
  logic hv_q, hv_d;
  req_t rq_q, rq_d;
  rsp_t rs_q, rs_d;
  logic [SW-1:0] cur_q, cur_d, end_q, end_d, run_q, run_d, firsts_q, firsts_d;
  logic [SW-1:0] visits_q, visits_d;
  logic got_q, got_d, clr_q, clr_d;
  logic [AW-1:0] rst_w_q, rst_w_d;
  logic rst_done_q, rst_done_d;
  logic [WORD_BITS-1:0] wbuf_q, wbuf_d, rdata;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [WORD_BITS-1:0] wdata;
  logic [SW-1:0] n;
  logic [AW-1:0] cur_word;
  logic [BW-1:0] cur_bit;

  assign n = (cfg_q > MAX_SLOTS) ? SW'(MAX_SLOTS) : SW'(cfg_q);
  assign cur_word = AW'(cur_q >> BW);
  assign cur_bit = BW'(cur_q);

  bsa_ram #(.Width(WORD_BITS), .Depth(NWords)) u_map (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_INIT; cfg_q <= 11'd1024; cnt_q <= CountW'(1024);
      hint_q <= '0; hv_q <= 1'b0; rst_w_q <= '0; rst_done_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; hint_q <= hint_d; hv_q <= hv_d;
      rst_w_q <= rst_w_d; rst_done_q <= rst_done_d;
      if (cfg_we_i) cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; rs_q <= rs_d; cur_q <= cur_d; end_q <= end_d; run_q <= run_d;
    firsts_q <= firsts_d; got_q <= got_d; clr_q <= clr_d; wbuf_q <= wbuf_d;
    visits_q <= visits_d;
  end

  assign req_stall_o = (st_q != ST_IDLE);
  assign rsp_valid_o = (st_q == ST_DONE);
  assign rsp_data_o = rs_q;

  always_comb begin
    logic [WORD_BITS-1:0] live;
    logic [SW-1:0] base;
    logic b;
    st_d = st_q; cnt_d = cnt_q; hint_d = hint_q; hv_d = hv_q; rq_d = rq_q;
    rs_d = rs_q; cur_d = cur_q; end_d = end_q; run_d = run_q;
    firsts_d = firsts_q; got_d = got_q; clr_d = clr_q; wbuf_d = wbuf_q;
    visits_d = visits_q; rst_w_d = rst_w_q;
    rst_done_d = rst_done_q;
    we = 1'b0; waddr = cur_word; wdata = wbuf_q; raddr = cur_word;
    base = SW'(rst_w_q) << BW;
    live = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      live[i] = rst_done_q ? ((base + SW'(i)) < n) : 1'b1;
    end
    b = wbuf_q[cur_bit];
    unique case (st_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          rq_d = req_data_i;
          rs_d = '0; rs_d.status = 1'b1; rs_d.free_total = cnt_q;
          got_d = 1'b0; run_d = '0; visits_d = '0; clr_d = 1'b0;
          unique case (kind_e'(req_data_i.kind))
            KIND_INIT: begin rst_w_d = '0; st_d = ST_INIT; end
            KIND_TEST, KIND_FREE: begin
              cur_d = SW'(req_data_i.slot_index);
              st_d = (SW'(req_data_i.slot_index) < n) ? ST_RD : ST_DONE;
            end
            KIND_ALLOC: begin
              if (cnt_q == '0 || n == '0) st_d = ST_DONE;
              else if (hv_q && hint_q < n) begin
                cur_d = hint_q; st_d = ST_RD;
              end else begin
                cur_d = '0; st_d = ST_SCAN_RD;
              end
            end
            KIND_ALLOC_RUN: begin
              if (req_data_i.run_length == '0 || SW'(req_data_i.run_length) > n
                  || req_data_i.run_length > cnt_q) st_d = ST_DONE;
              else begin cur_d = '0; end_d = n; st_d = ST_SCAN_RD; end
            end
            KIND_FREE_RUN: begin
              if (req_data_i.run_length == '0 || SW'(req_data_i.slot_index)
                  + SW'(req_data_i.run_length) > n) st_d = ST_DONE;
              else begin
                cur_d = SW'(req_data_i.slot_index);
                end_d = SW'(req_data_i.slot_index) + SW'(req_data_i.run_length);
                st_d = ST_SCAN_RD;
              end
            end
            default: st_d = ST_DONE;
          endcase
        end
      end
      ST_INIT: begin
        we = 1'b1; waddr = rst_w_q; wdata = live;
        if (rst_w_q == AW'(NWords - 1)) begin
          rst_w_d = '0;
          if (rst_done_q) begin
            cnt_d = CountW'(n); hv_d = 1'b0; rs_d.status = 1'b0;
            rs_d.free_total = CountW'(n); st_d = ST_DONE;
          end else st_d = ST_IDLE;
          rst_done_d = 1'b1;
        end else rst_w_d = rst_w_q + 1'b1;
      end
      ST_RD: st_d = ST_WT;
      ST_WT: begin wbuf_d = rdata; st_d = ST_MOD; end
      ST_MOD: begin
        unique case (kind_e'(rq_q.kind))
          KIND_TEST: begin rs_d.bit_value = b; rs_d.status = 1'b0; end
          KIND_FREE: if (!b) begin
            wbuf_d[cur_bit] = 1'b1; we = 1'b1; wdata = wbuf_d;
            if (cnt_q < CountW'(MAX_SLOTS)) cnt_d = cnt_q + 1'b1;
            hint_d = cur_q; hv_d = 1'b1; rs_d.status = 1'b0;
          end
          default: begin // single allocate, hint path
            if (b) begin
              wbuf_d[cur_bit] = 1'b0; we = 1'b1; wdata = wbuf_d;
              cnt_d = cnt_q - 1'b1; rs_d.status = 1'b0;
              rs_d.granted_slot = SlotW'(cur_q);
            end
          end
        endcase
        rs_d.free_total = cnt_d;
        st_d = ST_DONE;
        if (kind_e'(rq_q.kind) == KIND_ALLOC && !b) begin
          cur_d = ((hint_q + 1'b1) >= n) ? '0 : hint_q + 1'b1;
          cur_d = (cur_d >> BW) << BW;
          st_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: st_d = ST_SCAN_WT;
      ST_SCAN_WT: begin wbuf_d = rdata; st_d = ST_SCAN; end
      ST_SCAN: begin
        // one slot per cycle within a word; word written back when leaving it
        logic [SW-1:0] nxt;
        logic fin;
        nxt = cur_q + 1'b1; fin = 1'b0;
        unique case (kind_e'(rq_q.kind))
          KIND_ALLOC: begin
            if (b && cur_q < n) begin
              wbuf_d[cur_bit] = 1'b0; cnt_d = cnt_q - 1'b1;
              rs_d.status = 1'b0; rs_d.granted_slot = SlotW'(cur_q); fin = 1'b1;
            end else begin
              visits_d = visits_q + 1'b1;
              if (visits_d >= SW'(NWords * WORD_BITS)) fin = 1'b1;
              if (nxt >= SW'(NWords * WORD_BITS) || nxt >= ((n + SW'(WORD_BITS - 1))
                  >> BW) << BW) nxt = '0;
            end
          end
          KIND_ALLOC_RUN: begin
            if (!clr_q) begin
              run_d = b ? run_q + 1'b1 : '0;
              if (run_d == SW'(rq_q.run_length)) begin
                clr_d = 1'b1; firsts_d = cur_q + 1'b1 - SW'(rq_q.run_length);
                end_d = cur_q + 1'b1; nxt = firsts_d;
                rs_d.granted_slot = SlotW'(firsts_d);
              end else if (nxt >= end_q) fin = 1'b1;
            end else begin
              wbuf_d[cur_bit] = 1'b0;
              if (nxt >= end_q) begin
                fin = 1'b1; rs_d.status = 1'b0;
                cnt_d = cnt_q - CountW'(rq_q.run_length);
              end
            end
          end
          default: begin // free run
            if (!b) begin
              wbuf_d[cur_bit] = 1'b1;
              if (cnt_q < CountW'(MAX_SLOTS)) cnt_d = cnt_q + 1'b1;
              if (!got_q) begin hint_d = cur_q; got_d = 1'b1; end
            end
            if (nxt >= end_q) begin
              fin = 1'b1; hv_d = got_d; rs_d.status = 1'b0;
            end
          end
        endcase
        rs_d.free_total = cnt_d;
        if (fin || (nxt >> BW) != (cur_q >> BW)) begin
          we = 1'b1; wdata = wbuf_d;
        end
        if (fin) st_d = ST_DONE;
        else begin
          cur_d = nxt;
          if ((nxt >> BW) != (cur_q >> BW)) st_d = ST_SCAN_RD;
          else if (kind_e'(rq_q.kind) == KIND_ALLOC_RUN && clr_d && !clr_q)
            st_d = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        clr_d = 1'b0;
        if (!rsp_stall_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  `BSA_ASSERT(a_busy_stall, clk_i, rst_ni, rsp_valid_o |-> req_stall_o,
    "result pending while requests taken")
  `BSA_ASSERT(a_rsp_hold, clk_i, rst_ni,
    (rsp_valid_o && rsp_stall_i) |=> (rsp_valid_o && $stable(rsp_data_o)),
    "stalled result changed")
  `BSA_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= CountW'(MAX_SLOTS),
    "free count above capacity")
endmodule
